// ----- rtl/brl_pkg.sv -----
// Shared types and codes of the Bresenham line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

  // Operation code carried by each input item.
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } brl_op_e;

  // Per-line orientation flags produced by the setup logic.
  typedef struct packed {
    logic steep;      // 1 when y is the major axis
    logic minor_neg;  // 1 when the minor coordinate steps downward
  } brl_line_flags_t;

endpackage

// ----- rtl/brl_if.sv -----
// Valid/ready channel interfaces for line commands and pixel results.
`timescale 1ns / 1ps

interface brl_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [0:0]            operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface brl_out_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  pixel_valid;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel, output ready);
endinterface

// ----- rtl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer: input register, line state and result register.
`timescale 1ns / 1ps

// Takes one command item per clock and returns exactly one result item per command. A start
// item orders the two endpoints along the major axis and returns the first pixel; each next
// item returns the following pixel, with last_pixel set on the line's end point, or a result
// with pixel_valid low when no line is active. Items flow through an input register and a
// result register, so a result is offered once its command has passed the input register and
// loaded the result register, and the block sustains one item per cycle as long as the result
// side keeps ready high; the line state is updated in the same cycle that the result register
// loads, which sets that rate.

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  brl_in_if.sink              in_i,
  brl_out_if.source           out_o
);
  import brl_pkg::*;

  localparam int TermBits = COORD_BITS + 3;

  // Input register.
  logic                  s1_valid_q;
  brl_op_e               s1_op_q;
  logic [COORD_BITS-1:0] s1_ax_q;
  logic [COORD_BITS-1:0] s1_ay_q;
  logic [COORD_BITS-1:0] s1_bx_q;
  logic [COORD_BITS-1:0] s1_by_q;

  // Line state.
  logic                  active_q, active_d;
  brl_line_flags_t       flags_q, flags_d;
  logic [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic [COORD_BITS-1:0] minor_pos_q, minor_pos_d;
  logic [COORD_BITS-1:0] major_stop_q, major_stop_d;
  logic [COORD_BITS-1:0] major_delta_q, major_delta_d;
  logic [COORD_BITS-1:0] minor_delta_q, minor_delta_d;
  logic signed [TermBits-1:0] term_q, term_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] px_q, px_d;
  logic [COORD_BITS-1:0] py_q, py_d;
  logic                  pvalid_q, pvalid_d;
  logic                  last_q, last_d;

  // Setup and step outputs.
  brl_line_flags_t       su_flags;
  logic [COORD_BITS-1:0] su_major_start;
  logic [COORD_BITS-1:0] su_minor_start;
  logic [COORD_BITS-1:0] su_major_stop;
  logic [COORD_BITS-1:0] su_major_delta;
  logic [COORD_BITS-1:0] su_minor_delta;
  logic signed [TermBits-1:0] su_term;
  logic [COORD_BITS-1:0] st_major_pos;
  logic [COORD_BITS-1:0] st_minor_pos;
  logic signed [TermBits-1:0] st_term;

  logic out_free;
  logic process;

  brl_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .ax_i          (s1_ax_q),
    .ay_i          (s1_ay_q),
    .bx_i          (s1_bx_q),
    .by_i          (s1_by_q),
    .flags_o       (su_flags),
    .major_start_o (su_major_start),
    .minor_start_o (su_minor_start),
    .major_stop_o  (su_major_stop),
    .major_delta_o (su_major_delta),
    .minor_delta_o (su_minor_delta),
    .term_o        (su_term)
  );

  brl_step #(.COORD_BITS(COORD_BITS)) u_step (
    .flags_i       (flags_q),
    .major_pos_i   (major_pos_q),
    .minor_pos_i   (minor_pos_q),
    .major_delta_i (major_delta_q),
    .minor_delta_i (minor_delta_q),
    .term_i        (term_q),
    .major_pos_o   (st_major_pos),
    .minor_pos_o   (st_minor_pos),
    .term_o        (st_term)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign process    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_comb begin
    active_d      = active_q;
    flags_d       = flags_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_stop_d  = major_stop_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    term_d        = term_q;
    out_valid_d   = out_valid_q;
    px_d          = px_q;
    py_d          = py_q;
    pvalid_d      = pvalid_q;
    last_d        = last_q;

    if (process) begin
      out_valid_d = 1'b1;
      case (s1_op_q)
        OP_START: begin
          flags_d       = su_flags;
          major_pos_d   = su_major_start;
          minor_pos_d   = su_minor_start;
          major_stop_d  = su_major_stop;
          major_delta_d = su_major_delta;
          minor_delta_d = su_minor_delta;
          term_d        = su_term;
          active_d      = (su_major_start != su_major_stop);
          px_d          = su_flags.steep ? su_minor_start : su_major_start;
          py_d          = su_flags.steep ? su_major_start : su_minor_start;
          pvalid_d      = 1'b1;
          last_d        = (su_major_start == su_major_stop);
        end
        OP_NEXT: begin
          if (active_q) begin
            major_pos_d = st_major_pos;
            minor_pos_d = st_minor_pos;
            term_d      = st_term;
            active_d    = (st_major_pos != major_stop_q);
            px_d        = flags_q.steep ? st_minor_pos : st_major_pos;
            py_d        = flags_q.steep ? st_major_pos : st_minor_pos;
            pvalid_d    = 1'b1;
            last_d      = (st_major_pos == major_stop_q);
          end else begin
            px_d     = '0;
            py_d     = '0;
            pvalid_d = 1'b0;
            last_d   = 1'b0;
          end
        end
        default: begin
          out_valid_d = out_valid_q;
        end
      endcase
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q <= brl_op_e'(in_i.operation);
      s1_ax_q <= in_i.start_x;
      s1_ay_q <= in_i.start_y;
      s1_bx_q <= in_i.end_x;
      s1_by_q <= in_i.end_y;
    end
    flags_q       <= flags_d;
    major_pos_q   <= major_pos_d;
    minor_pos_q   <= minor_pos_d;
    major_stop_q  <= major_stop_d;
    major_delta_q <= major_delta_d;
    minor_delta_q <= minor_delta_d;
    term_q        <= term_d;
    px_q          <= px_d;
    py_q          <= py_d;
    pvalid_q      <= pvalid_d;
    last_q        <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_valid = pvalid_q;
  assign out_o.last_pixel  = last_q;

endmodule

// ----- rtl/brl_setup.sv -----
// Line setup: major axis choice, endpoint ordering, deltas and initial decision term.
`timescale 1ns / 1ps

module brl_setup #(
  parameter int COORD_BITS = 10
) (
  input  logic [COORD_BITS-1:0]   ax_i,
  input  logic [COORD_BITS-1:0]   ay_i,
  input  logic [COORD_BITS-1:0]   bx_i,
  input  logic [COORD_BITS-1:0]   by_i,
  output brl_pkg::brl_line_flags_t flags_o,
  output logic [COORD_BITS-1:0]   major_start_o,
  output logic [COORD_BITS-1:0]   minor_start_o,
  output logic [COORD_BITS-1:0]   major_stop_o,
  output logic [COORD_BITS-1:0]   major_delta_o,
  output logic [COORD_BITS-1:0]   minor_delta_o,
  output logic signed [COORD_BITS+2:0] term_o
);
  import brl_pkg::*;

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  steep;
  logic [COORD_BITS-1:0] maj0;
  logic [COORD_BITS-1:0] min0;
  logic [COORD_BITS-1:0] maj1;
  logic [COORD_BITS-1:0] min1;
  logic                  minor_neg;
  logic [COORD_BITS-1:0] major_delta;
  logic [COORD_BITS-1:0] minor_delta;

  always_comb begin
    adx   = (ax_i > bx_i) ? (ax_i - bx_i) : (bx_i - ax_i);
    ady   = (ay_i > by_i) ? (ay_i - by_i) : (by_i - ay_i);
    // Ties go to y as the major axis.
    steep = !(ady < adx);
    if (!steep) begin
      if (ax_i > bx_i) begin
        maj0 = bx_i; min0 = by_i; maj1 = ax_i; min1 = ay_i;
      end else begin
        maj0 = ax_i; min0 = ay_i; maj1 = bx_i; min1 = by_i;
      end
    end else begin
      if (ay_i > by_i) begin
        maj0 = by_i; min0 = bx_i; maj1 = ay_i; min1 = ax_i;
      end else begin
        maj0 = ay_i; min0 = ax_i; maj1 = by_i; min1 = bx_i;
      end
    end
    major_delta = maj1 - maj0;
    minor_neg   = (min1 < min0);
    minor_delta = minor_neg ? (min0 - min1) : (min1 - min0);
  end

  assign flags_o.steep     = steep;
  assign flags_o.minor_neg = minor_neg;
  assign major_start_o     = maj0;
  assign minor_start_o     = min0;
  assign major_stop_o      = maj1;
  assign major_delta_o     = major_delta;
  assign minor_delta_o     = minor_delta;
  assign term_o = $signed({2'b00, minor_delta, 1'b0}) - $signed({3'b000, major_delta});

endmodule

// ----- rtl/brl_step.sv -----
// One Bresenham step: advance the major axis and conditionally the minor axis.
`timescale 1ns / 1ps

module brl_step #(
  parameter int COORD_BITS = 10
) (
  input  brl_pkg::brl_line_flags_t     flags_i,
  input  logic [COORD_BITS-1:0]        major_pos_i,
  input  logic [COORD_BITS-1:0]        minor_pos_i,
  input  logic [COORD_BITS-1:0]        major_delta_i,
  input  logic [COORD_BITS-1:0]        minor_delta_i,
  input  logic signed [COORD_BITS+2:0] term_i,
  output logic [COORD_BITS-1:0]        major_pos_o,
  output logic [COORD_BITS-1:0]        minor_pos_o,
  output logic signed [COORD_BITS+2:0] term_o
);
  import brl_pkg::*;

  logic signed [COORD_BITS+2:0] two_minor;
  logic signed [COORD_BITS+2:0] two_major;
  logic                         term_pos;

  assign two_minor = $signed({2'b00, minor_delta_i, 1'b0});
  assign two_major = $signed({2'b00, major_delta_i, 1'b0});
  assign term_pos  = !term_i[COORD_BITS+2] && (term_i != '0);

  always_comb begin
    if (term_pos) begin
      minor_pos_o = flags_i.minor_neg ? (minor_pos_i - COORD_BITS'(1))
                                      : (minor_pos_i + COORD_BITS'(1));
      term_o      = term_i + (two_minor - two_major);
    end else begin
      minor_pos_o = minor_pos_i;
      term_o      = term_i + two_minor;
    end
    major_pos_o = major_pos_i + COORD_BITS'(1);
  end

endmodule

// ----- rtl/brl_checker.sv -----
// Port-level checks of the line rasterizer and their attachment to the top level.
`timescale 1ns / 1ps

module brl_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] pixel_x_i,
  input logic [COORD_BITS-1:0] pixel_y_i,
  input logic                  pixel_valid_i,
  input logic                  last_pixel_i
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i)
      && $stable(pixel_valid_i) && $stable(last_pixel_i))
    else $error("stalled result changed");

  // An item accepted while the result side keeps taking shows up once it reaches the result register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after accepted item");

  // Only a real pixel can close a line.
  a_last_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_pixel_i |-> pixel_valid_i)
    else $error("last_pixel without pixel_valid");

  // An empty result carries zero coordinates.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pixel_valid_i |-> pixel_x_i == '0 && pixel_y_i == '0)
    else $error("empty result with nonzero coordinates");

endmodule

bind bresenham_line_rasterizer brl_checker #(.COORD_BITS(COORD_BITS)) u_brl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_x_i     (out_o.pixel_x),
  .pixel_y_i     (out_o.pixel_y),
  .pixel_valid_i (out_o.pixel_valid),
  .last_pixel_i  (out_o.last_pixel)
);

// ----- test/tb.sv -----
// Self-checking testbench of the Bresenham line rasterizer with random handshake idling.
`timescale 1ns / 1ps

module tb;
  import brl_pkg::*;

  localparam int CB         = 10;
  localparam int CMAX       = (1 << CB) - 1;
  localparam int RAND_ITEMS = 900;
  localparam int CALM_ITEMS = 120;

  typedef struct {
    brl_op_e         op;
    logic [CB-1:0]   sx;
    logic [CB-1:0]   sy;
    logic [CB-1:0]   ex;
    logic [CB-1:0]   ey;
  } line_cmd_t;

  typedef struct {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic          pvalid;
    logic          plast;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  brl_in_if  #(.COORD_BITS(CB)) in_if ();
  brl_out_if #(.COORD_BITS(CB)) out_if ();

  bresenham_line_rasterizer #(.COORD_BITS(CB)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  line_cmd_t pending_cmds[$];
  pixel_t    pixel_expect[$];
  int        err_cnt;
  logic      cmd_taken;
  int        cmd_gap;
  int        stall_left;

  // Line state of the predictor.
  logic                 ln_active;
  brl_line_flags_t      ln_flags;
  logic [CB-1:0]        maj_pos;
  logic [CB-1:0]        min_pos;
  logic [CB-1:0]        maj_stop;
  logic [CB-1:0]        maj_delta;
  logic [CB-1:0]        min_delta;
  logic signed [CB+2:0] dec_term;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic pixel_t line_pixel();
    pixel_t p;
    p.px     = ln_flags.steep ? min_pos : maj_pos;
    p.py     = ln_flags.steep ? maj_pos : min_pos;
    p.pvalid = 1'b1;
    p.plast  = !ln_active;
    return p;
  endfunction

  task automatic raster_step(input line_cmd_t c, output pixel_t p);
    int adx, ady, m0, n0, m1, n1, t;
    if (c.op == OP_START) begin
      adx = (c.sx > c.ex) ? int'(c.sx) - int'(c.ex) : int'(c.ex) - int'(c.sx);
      ady = (c.sy > c.ey) ? int'(c.sy) - int'(c.ey) : int'(c.ey) - int'(c.sy);
      if (ady < adx) begin
        ln_flags.steep = 1'b0;
        if (c.sx > c.ex) begin
          m0 = int'(c.ex); n0 = int'(c.ey); m1 = int'(c.sx); n1 = int'(c.sy);
        end else begin
          m0 = int'(c.sx); n0 = int'(c.sy); m1 = int'(c.ex); n1 = int'(c.ey);
        end
      end else begin
        // Equal deltas fall here, so y is major.
        ln_flags.steep = 1'b1;
        if (c.sy > c.ey) begin
          m0 = int'(c.ey); n0 = int'(c.ex); m1 = int'(c.sy); n1 = int'(c.sx);
        end else begin
          m0 = int'(c.sy); n0 = int'(c.sx); m1 = int'(c.ey); n1 = int'(c.ex);
        end
      end
      maj_pos            = CB'(m0);
      min_pos            = CB'(n0);
      maj_stop           = CB'(m1);
      maj_delta          = CB'(m1 - m0);
      ln_flags.minor_neg = (n1 < n0);
      min_delta          = CB'(ln_flags.minor_neg ? n0 - n1 : n1 - n0);
      dec_term           = (CB+3)'(2 * int'(min_delta) - int'(maj_delta));
      ln_active          = (maj_pos != maj_stop);
      p = line_pixel();
    end else if (!ln_active) begin
      p.px = '0; p.py = '0; p.pvalid = 1'b0; p.plast = 1'b0;
    end else begin
      t = int'(dec_term);
      if (t > 0) begin
        min_pos = ln_flags.minor_neg ? min_pos - CB'(1) : min_pos + CB'(1);
        t       = t + 2 * int'(min_delta) - 2 * int'(maj_delta);
      end else begin
        t = t + 2 * int'(min_delta);
      end
      dec_term  = (CB+3)'(t);
      maj_pos   = maj_pos + CB'(1);
      ln_active = (maj_pos != maj_stop);
      p = line_pixel();
    end
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
  endfunction

  // Queues a start item followed by a number of next items with random filler coordinates.
  task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                            input int nexts);
    line_cmd_t c;
    c.op = OP_START;
    c.sx = CB'(sx); c.sy = CB'(sy); c.ex = CB'(ex); c.ey = CB'(ey);
    pending_cmds.push_back(c);
    repeat (nexts) begin
      c.op = OP_NEXT;
      c.sx = CB'($urandom); c.sy = CB'($urandom);
      c.ex = CB'($urandom); c.ey = CB'($urandom);
      pending_cmds.push_back(c);
    end
  endtask

  task automatic queue_next();
    line_cmd_t c;
    c.op = OP_NEXT;
    c.sx = CB'($urandom); c.sy = CB'($urandom);
    c.ex = CB'($urandom); c.ey = CB'($urandom);
    pending_cmds.push_back(c);
  endtask

  task automatic build_stimulus();
    int total, sx, sy, ex, ey, span, len, nexts;
    // Next items with no line active.
    queue_next();
    queue_next();
    // Single-point lines at both corners.
    queue_line(0, 0, 0, 0, 1);
    queue_line(CMAX, CMAX, CMAX, CMAX, 0);
    // Long flat line, abandoned by the following start.
    queue_line(0, 0, CMAX, 0, 3);
    // Equal deltas, abandoned as well.
    queue_line(0, 0, CMAX, CMAX, 2);
    // Reversed endpoints with a descending minor axis.
    queue_line(CMAX, 0, 0, CMAX, 2);
    queue_line(5, CMAX, 3, 0, 2);
    // Short line walked to its end and one past it.
    queue_line(10, 10, 13, 12, 4);
    total = pending_cmds.size() + RAND_ITEMS;
    while (pending_cmds.size() < total) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: a start with random endpoints or a stray next.
        if ($urandom_range(0, 1) == 0) begin
          queue_line($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                     $urandom_range(0, CMAX), $urandom_range(0, CMAX), 0);
        end else begin
          queue_next();
        end
      end else begin
        sx   = $urandom_range(0, CMAX);
        sy   = $urandom_range(0, CMAX);
        span = ($urandom_range(0, 9) == 0) ? CMAX : $urandom_range(0, 12);
        ex   = clamp_coord(sx + $urandom_range(0, 2 * span) - span);
        ey   = clamp_coord(sy + $urandom_range(0, 2 * span) - span);
        len  = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > len) len = (ey > sy ? ey - sy : sy - ey);
        case ($urandom_range(0, 7))
          0: nexts = $urandom_range(0, len);
          1: nexts = len + $urandom_range(1, 2);
          default: nexts = len;
        endcase
        if (nexts > 30) nexts = $urandom_range(0, 30);
        queue_line(sx, sy, ex, ey, nexts);
      end
    end
  endtask

  // Input side: a new item goes out once the current one has been accepted.
  always @(negedge clk_i) begin : cmd_driver
    line_cmd_t c;
    if (rst_ni && (!in_if.valid || cmd_taken)) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_cmds.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
        cmd_gap = $urandom_range(0, 2);
        in_if.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_if.operation <= c.op;
        in_if.start_x   <= c.sx;
        in_if.start_y   <= c.sy;
        in_if.end_x     <= c.ex;
        in_if.end_y     <= c.ey;
        in_if.valid     <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in short bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (pending_cmds.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : pixel_monitor
    line_cmd_t c;
    pixel_t    p;
    pixel_t    e;
    cmd_taken <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      c.op = brl_op_e'(in_if.operation);
      c.sx = in_if.start_x; c.sy = in_if.start_y;
      c.ex = in_if.end_x;   c.ey = in_if.end_y;
      raster_step(c, p);
      pixel_expect.push_back(p);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_expect.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d valid=%0b last=%0b", $time,
                 out_if.pixel_x, out_if.pixel_y, out_if.pixel_valid, out_if.last_pixel);
        err_cnt++;
      end else begin
        e = pixel_expect.pop_front();
        if (out_if.pixel_x !== e.px) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, e.px, out_if.pixel_x);
          err_cnt++;
        end
        if (out_if.pixel_y !== e.py) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, e.py, out_if.pixel_y);
          err_cnt++;
        end
        if (out_if.pixel_valid !== e.pvalid) begin
          $display("%0t: pixel_valid expected %0b actual %0b", $time, e.pvalid,
                   out_if.pixel_valid);
          err_cnt++;
        end
        if (out_if.last_pixel !== e.plast) begin
          $display("%0t: last_pixel expected %0b actual %0b", $time, e.plast,
                   out_if.last_pixel);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    err_cnt         = 0;
    cmd_gap         = 0;
    stall_left      = 0;
    cmd_taken       = 1'b0;
    ln_active       = 1'b0;
    ln_flags        = '0;
    maj_pos         = '0;
    min_pos         = '0;
    maj_stop        = '0;
    maj_delta       = '0;
    min_delta       = '0;
    dec_term        = '0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_START;
    in_if.start_x   = '0;
    in_if.start_y   = '0;
    in_if.end_x     = '0;
    in_if.end_y     = '0;
    out_if.ready    = 1'b0;
    build_stimulus();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_cmds.size() != 0 || in_if.valid) @(posedge clk_i);
    while (pixel_expect.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pixel_expect.size() == 0 && err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/brl_pkg.sv
rtl/brl_if.sv
rtl/brl_setup.sv
rtl/brl_step.sv
rtl/bresenham_line_rasterizer.sv
rtl/brl_checker.sv
test/tb.sv
